FILE: src/quaternion_vector_rotate_unit_defines.svh
// Assertion helpers for the quaternion rotate unit. All use clk / rst_n of the enclosing module.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QVR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define QVR_ASSERT(lbl, prop, msg)
`define QVR_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

FILE: src/qvr_pkg.sv
`default_nettype none
package qvr_pkg;
  localparam int VEC_W  = 32;
  localparam int QUAT_W = 16;
  localparam int ACC_W  = 69;             // signed sum of the three product terms
  localparam int LIMB_W = 23;
  localparam int NLIMB  = 3;
  localparam int MAG_W  = LIMB_W * NLIMB; // magnitude split for the square
  localparam int SQ_W   = 2 * MAG_W;
  localparam int QUO_W  = 32;             // digits of the rounded quotient
  localparam logic [QUO_W-1:0] QUO_CAP = 32'h8000_0001;
  localparam logic [QUO_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic vld;
    logic zq;
  } qvr_ctl_t;
endpackage
`default_nettype wire

FILE: src/qvr_prod.sv
`default_nettype none
// Four register stages: raw products, sums, wide products, accumulation.
module qvr_prod import qvr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     ce,
  input  wire logic                     vld_i,
  input  wire logic signed [VEC_W-1:0]  v_i [3],
  input  wire logic signed [QUAT_W-1:0] u_i [3],
  input  wire logic signed [QUAT_W-1:0] w_i,
  output qvr_ctl_t                      ctl_o,
  output logic signed [ACC_W-1:0]       acc_o [3],
  output logic [32:0]                   s_o
);
  // stage 1
  logic vld1_r;
  logic signed [47:0] puv_r [3][3];
  logic signed [31:0] ww_r;
  logic signed [31:0] uu_r [3];
  logic signed [VEC_W-1:0] v1_r [3];
  logic signed [QUAT_W-1:0] u1_r [3];
  logic signed [QUAT_W-1:0] w1_r;
  // stage 2
  qvr_ctl_t ctl2_r;
  logic [32:0] s2_r;
  logic signed [34:0] a2_r;
  logic signed [50:0] b2_r;
  logic signed [48:0] c2_r [3];
  logic signed [17:0] m2w_r;
  logic signed [VEC_W-1:0] v2_r [3];
  logic signed [QUAT_W-1:0] u2_r [3];
  // stage 3
  qvr_ctl_t ctl3_r;
  logic [32:0] s3_r;
  logic signed [66:0] t1_r [3];
  logic signed [66:0] t2_r [3];
  logic signed [66:0] t3_r [3];
  // stage 4
  qvr_ctl_t ctl4_r;
  logic [32:0] s4_r;
  logic signed [ACC_W-1:0] acc4_r [3];

  logic signed [34:0] usq_nxt;
  logic signed [34:0] ss_nxt;
  logic signed [49:0] dot_nxt;

  always_comb begin
    usq_nxt = 35'(uu_r[0]) + 35'(uu_r[1]) + 35'(uu_r[2]);
    ss_nxt  = usq_nxt + 35'(ww_r);
    dot_nxt = 50'(puv_r[0][0]) + 50'(puv_r[1][1]) + 50'(puv_r[2][2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (ce) begin
      vld1_r <= vld_i;
      ctl2_r <= '{vld: vld1_r, zq: (ss_nxt == 35'sd0)};
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          puv_r[i][j] <= 48'(u_i[i]) * 48'(v_i[j]);
        end
        uu_r[i] <= 32'(u_i[i]) * 32'(u_i[i]);
        v1_r[i] <= v_i[i];
        u1_r[i] <= u_i[i];
      end
      ww_r <= 32'(w_i) * 32'(w_i);
      w1_r <= w_i;

      s2_r   <= ss_nxt[32:0];
      a2_r   <= 35'(ww_r) - usq_nxt;
      b2_r   <= {dot_nxt, 1'b0};
      c2_r[0] <= 49'(puv_r[1][2]) - 49'(puv_r[2][1]);
      c2_r[1] <= 49'(puv_r[2][0]) - 49'(puv_r[0][2]);
      c2_r[2] <= 49'(puv_r[0][1]) - 49'(puv_r[1][0]);
      m2w_r  <= -(18'(w1_r) <<< 1);
      v2_r   <= v1_r;
      u2_r   <= u1_r;

      s3_r <= s2_r;
      for (int i = 0; i < 3; i++) begin
        t1_r[i] <= 67'(a2_r) * 67'(v2_r[i]);
        t2_r[i] <= 67'(b2_r) * 67'(u2_r[i]);
        t3_r[i] <= 67'(m2w_r) * 67'(c2_r[i]);
      end

      s4_r <= s3_r;
      for (int i = 0; i < 3; i++) begin
        acc4_r[i] <= ACC_W'(t1_r[i]) + ACC_W'(t2_r[i]) + ACC_W'(t3_r[i]);
      end
    end
  end

  assign ctl_o  = ctl4_r;
  assign acc_o  = acc4_r;
  assign s_o    = s4_r;
endmodule
`default_nettype wire

FILE: src/qvr_digit.sv
`default_nettype none
// One quotient digit for all three lanes. Holds R = 4V^2 - S*k^2, F = S*k
// (k = 2m-1); the digit is kept if R stays nonnegative and m <= QUO_CAP.
module qvr_digit import qvr_pkg::*; #(
  parameter int J  = 0,
  parameter int RW = 141
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    ce,
  input  wire qvr_ctl_t                ctl_i,
  input  wire logic signed [RW-1:0]    s_i,
  input  wire logic signed [RW-1:0]    r_i [3],
  input  wire logic signed [RW-1:0]    f_i [3],
  input  wire logic [QUO_W-1:0]        m_i [3],
  input  wire logic [2:0]              neg_i,
  output qvr_ctl_t                     ctl_o,
  output logic signed [RW-1:0]         s_o,
  output logic signed [RW-1:0]         r_o [3],
  output logic signed [RW-1:0]         f_o [3],
  output logic [QUO_W-1:0]             m_o [3],
  output logic [2:0]                   neg_o
);
  logic signed [RW-1:0] delta [3];
  logic signed [RW-1:0] trial [3];
  logic [2:0] take;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      delta[k] = (f_i[k] <<< (J + 2)) + (s_i <<< (2 * J + 2));
      trial[k] = r_i[k] - delta[k];
      take[k]  = !trial[k][RW-1] &&
                 (({1'b0, m_i[k]} + ((QUO_W+1)'(1) << J)) <= {1'b0, QUO_CAP});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (ce) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s_o   <= s_i;
      neg_o <= neg_i;
      for (int k = 0; k < 3; k++) begin
        r_o[k] <= take[k] ? trial[k] : r_i[k];
        f_o[k] <= take[k] ? (f_i[k] + (s_i <<< (J + 1))) : f_i[k];
        m_o[k] <= m_i[k] | (QUO_W'(take[k]) << J);
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/quaternion_vector_rotate_unit.sv
// Channel  Dir  Width  Contents
// in_      in   160    vec_x, vec_y, vec_z (32b each), quat_x, quat_y, quat_z, quat_w (16b each)
// out_     out  96+2   out_x, out_y, out_z in tdata; zero_quat, saturated in tuser
//
// One beat per cycle in and out while out_ does not stall; the pipeline has 4 product stages,
// 2 for the split 69-bit square, 32 quotient digit stages and 1 output stage.
// The digit chain, one bit of the rounded quotient per stage, sets the depth.
// Synchronous active-low reset clears only the control bits (valid and zero_quat).
// A stall on out_ freezes the whole pipeline; in_tready follows it.
`default_nettype none
`include "quaternion_vector_rotate_unit_defines.svh"
module quaternion_vector_rotate_unit import qvr_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 13
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [159:0] in_tdata,  // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata, // out_x, out_y, out_z
  output logic [1:0]        out_tuser  // zero_quat, saturated
);
  localparam int SW = 33 + 2 * QUAT_FRAC_BITS;
  localparam int RA = 2 * MAG_W + 2;
  localparam int RB = SW + 70;
  localparam int RW = ((RA > RB) ? RA : RB) + 1;

  logic ce;
  logic signed [VEC_W-1:0]  vin [3];
  logic signed [QUAT_W-1:0] uin [3];
  logic signed [QUAT_W-1:0] win;

  qvr_ctl_t ctl4;
  logic signed [ACC_W-1:0] acc4 [3];
  logic [32:0] s4;

  // square stage 1
  qvr_ctl_t ctl5_r;
  logic [32:0] s5_r;
  logic [2:0] neg5_r;
  logic [2*LIMB_W-1:0] pp5_r [3][NLIMB][NLIMB];
  // digit chain
  qvr_ctl_t ctl_c [33];
  logic signed [RW-1:0] s_c [33];
  logic signed [RW-1:0] r_c [33][3];
  logic signed [RW-1:0] f_c [33][3];
  logic [QUO_W-1:0] m_c [33][3];
  logic [2:0] neg_c [33];
  // output
  qvr_ctl_t ctlo_r;
  logic [95:0] data_r;
  logic sat_r;

  logic [MAG_W-1:0] mag [3];
  logic [SQ_W-1:0] sq [3];
  logic signed [RW-1:0] sfull;
  logic [QUO_W-1:0] res [3];
  logic [2:0] clip;

  assign ce        = !ctlo_r.vld || out_tready;
  assign in_tready = ce;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vin[k] = in_tdata[32*k +: 32];
      uin[k] = in_tdata[96 + 16*k +: 16];
    end
    win = in_tdata[144 +: 16];
  end

  qvr_prod u_prod (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .vld_i (in_tvalid),
    .v_i   (vin),
    .u_i   (uin),
    .w_i   (win),
    .ctl_o (ctl4),
    .acc_o (acc4),
    .s_o   (s4)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = acc4[k][ACC_W-1] ? MAG_W'(-acc4[k]) : MAG_W'(acc4[k]);
      sq[k] = '0;
      for (int a = 0; a < NLIMB; a++) begin
        for (int b = 0; b < NLIMB; b++) begin
          sq[k] = sq[k] + (SQ_W'(pp5_r[k][a][b]) << (LIMB_W * (a + b)));
        end
      end
    end
    sfull = RW'(s5_r) <<< (2 * QUAT_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r   <= '0;
      ctl_c[0] <= '0;
    end else if (ce) begin
      ctl5_r   <= ctl4;
      ctl_c[0] <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_r <= s4;
      for (int k = 0; k < 3; k++) begin
        neg5_r[k] <= acc4[k][ACC_W-1];
        for (int a = 0; a < NLIMB; a++) begin
          for (int b = 0; b < NLIMB; b++) begin
            pp5_r[k][a][b] <= mag[k][LIMB_W*a +: LIMB_W] * mag[k][LIMB_W*b +: LIMB_W];
          end
        end
      end
      // start at m = 0, k = -1: R = 4V^2 - S, F = -S
      s_c[0]   <= sfull;
      neg_c[0] <= neg5_r;
      for (int k = 0; k < 3; k++) begin
        r_c[0][k] <= (RW'(sq[k]) <<< 2) - sfull;
        f_c[0][k] <= -sfull;
        m_c[0][k] <= '0;
      end
    end
  end

  for (genvar g = 0; g < 32; g++) begin : g_dig
    qvr_digit #(.J(31 - g), .RW(RW)) u_dig (
      .clk   (clk),
      .rst_n (rst_n),
      .ce    (ce),
      .ctl_i (ctl_c[g]),
      .s_i   (s_c[g]),
      .r_i   (r_c[g]),
      .f_i   (f_c[g]),
      .m_i   (m_c[g]),
      .neg_i (neg_c[g]),
      .ctl_o (ctl_c[g+1]),
      .s_o   (s_c[g+1]),
      .r_o   (r_c[g+1]),
      .f_o   (f_c[g+1]),
      .m_o   (m_c[g+1]),
      .neg_o (neg_c[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip[k] = 1'b0;
      if (ctl_c[32].zq) begin
        res[k] = '0;
      end else if (!neg_c[32][k]) begin
        clip[k] = m_c[32][k] > POS_MAX;
        res[k]  = clip[k] ? POS_MAX : m_c[32][k];
      end else begin
        clip[k] = m_c[32][k] > NEG_MAX;
        res[k]  = clip[k] ? NEG_MAX : QUO_W'(0 - m_c[32][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlo_r <= '0;
    end else if (ce) begin
      ctlo_r <= ctl_c[32];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      data_r <= {res[2], res[1], res[0]};
      sat_r  <= |clip;
    end
  end

  assign out_tvalid = ctlo_r.vld;
  assign out_tdata  = data_r;
  assign out_tuser  = {sat_r, ctlo_r.zq};

  `QVR_ASSERT_IMP(a_zero_out, out_tvalid && out_tuser[0], out_tdata == 96'd0 && !out_tuser[1], "zero quaternion beat carries data")
  `QVR_ASSERT_IMP(a_quo_cap, ctl_c[32].vld, m_c[32][0] <= QUO_CAP && m_c[32][1] <= QUO_CAP && m_c[32][2] <= QUO_CAP, "quotient above cap")
  `QVR_ASSERT_IMP(a_sat_val, out_tvalid && out_tuser[1], out_tdata[31:0] == POS_MAX || out_tdata[31:0] == NEG_MAX || out_tdata[63:32] == POS_MAX || out_tdata[63:32] == NEG_MAX || out_tdata[95:64] == POS_MAX || out_tdata[95:64] == NEG_MAX, "saturated beat without clipped lane")
endmodule
`default_nettype wire
